[hw/rtl/i2rd_pkg.sv]
// Shared constants, control word types and microcode program for the radix digit converter.
package i2rd_pkg;

    // Datapath sizing
    localparam int VALUE_WIDTH  = 32;
    localparam int MAX_RADIX    = 16;
    localparam int RADIX_WIDTH  = 5;
    localparam int DIGIT_WIDTH  = 4;
    localparam int SYMBOL_WIDTH = 8;
    localparam int TABLE_WIDTH  = 64;
    localparam int CHUNK_BITS   = 8;
    localparam int NUM_CHUNKS   = VALUE_WIDTH / CHUNK_BITS;
    localparam int CHUNK_CNT_W  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int COUNT_WIDTH  = $clog2(VALUE_WIDTH + 1);
    localparam int INDEX_WIDTH  = $clog2(VALUE_WIDTH);
    localparam int CFG_IDX_W    = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    // Reset values of the configuration registers
    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET        = 5'd10;
    localparam logic [TABLE_WIDTH-1:0] SYMBOLS_LOW_RESET  = 64'h3736353433323130;
    localparam logic [TABLE_WIDTH-1:0] SYMBOLS_HIGH_RESET = 64'h6665646362613938;

    localparam logic [SYMBOL_WIDTH-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [RADIX_WIDTH-1:0]  RADIX_MIN  = 5'd2;
    localparam logic [RADIX_WIDTH-1:0]  RADIX_MAX  = RADIX_WIDTH'(MAX_RADIX);

    // Program counter and program step addresses
    typedef logic [2:0] step_t;
    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_DIV   = 3'd1;
    localparam step_t STEP_STORE = 3'd2;
    localparam step_t STEP_SIGN  = 3'd3;
    localparam step_t STEP_EMIT  = 3'd4;
    localparam step_t STEP_END   = 3'd5;

    // Datapath operation of one step
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_CHUNK,
        OP_STORE,
        OP_SIGN,
        OP_EMIT
    } op_t;

    // Jump condition of one step; the jump is taken when the condition holds
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NOT_START,
        COND_CHUNK_MORE,
        COND_MAG_MORE,
        COND_COUNT_MORE,
        COND_NEVER
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Microcode ROM
    function automatic ctrl_word_t ucode(input step_t pc);
        ctrl_word_t w;
        unique case (pc)
            STEP_IDLE:  w = '{op: OP_LOAD,      cond: COND_NOT_START,  target: STEP_IDLE};
            STEP_DIV:   w = '{op: OP_DIV_CHUNK, cond: COND_CHUNK_MORE, target: STEP_DIV};
            STEP_STORE: w = '{op: OP_STORE,     cond: COND_MAG_MORE,   target: STEP_DIV};
            STEP_SIGN:  w = '{op: OP_SIGN,      cond: COND_NEVER,      target: STEP_IDLE};
            STEP_EMIT:  w = '{op: OP_EMIT,      cond: COND_COUNT_MORE, target: STEP_EMIT};
            STEP_END:   w = '{op: OP_NOP,       cond: COND_ALWAYS,     target: STEP_IDLE};
            default:    w = '{op: OP_NOP,       cond: COND_ALWAYS,     target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/integer_to_radix_digits_core.sv]
// Microcoded signed integer to radix digit string converter.
// Each digit is the remainder of dividing the magnitude by the radix; the digits are stored,
//   then the minus sign (for a negative value) and the digits, most significant first, are strobed.
// A value occupies the block until its last character has gone (D = 1..32 digits); the
//   shared divider retires 8 quotient bits per cycle.
// Characters stream one per cycle on strobe; the receiver cannot stall them.
// Reset clears the program counter, output strobe and registers to 10 / "0123456789abcdef".
module integer_to_radix_digits_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [i2rd_pkg::VALUE_WIDTH-1:0] value,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [i2rd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [i2rd_pkg::TABLE_WIDTH-1:0]      cfg_data,
    output logic                                  strobe,
    output logic [i2rd_pkg::SYMBOL_WIDTH-1:0]     symbol,
    output logic                                  last
);
    import i2rd_pkg::*;

    // Configuration registers
    logic [RADIX_WIDTH-1:0] radix_reg;
    logic [TABLE_WIDTH-1:0] sym_low_reg;
    logic [TABLE_WIDTH-1:0] sym_high_reg;

    // Sequencer and datapath registers
    step_t                   pc_reg, pc_next;
    logic [VALUE_WIDTH-1:0]  mag_reg, mag_next;
    logic [DIGIT_WIDTH-1:0]  rem_reg, rem_next;
    logic [CHUNK_CNT_W-1:0]  chunk_reg, chunk_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic                    neg_reg, neg_next;
    logic [DIGIT_WIDTH-1:0]  digit_buf [VALUE_WIDTH];

    // Output registers
    logic                    strobe_reg, strobe_next;
    logic [SYMBOL_WIDTH-1:0] symbol_reg, symbol_next;
    logic                    last_reg, last_next;

    ctrl_word_t              cw;
    logic                    jump;
    logic [RADIX_WIDTH-1:0]  eff_radix;
    logic [CHUNK_BITS-1:0]   q_bits;
    logic [DIGIT_WIDTH-1:0]  chunk_rem;
    logic [RADIX_WIDTH-1:0]  trial;
    logic [INDEX_WIDTH-1:0]  rd_index;
    logic [DIGIT_WIDTH-1:0]  rd_digit_reg;
    logic [2*TABLE_WIDTH-1:0] sym_table;
    logic                    buf_we;

    assign cfg_ready = 1'b1;
    assign busy      = (pc_reg != STEP_IDLE);
    assign strobe    = strobe_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;

    // Fetch the control word of the current step
    assign cw = ucode(pc_reg);

    // Clamp the radix into the supported range
    always_comb
    begin
        priority if (radix_reg < RADIX_MIN)
            eff_radix = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            eff_radix = RADIX_MAX;
        else
            eff_radix = radix_reg;
    end

    // Restoring division over the top chunk of the magnitude
    always_comb
    begin
        chunk_rem = rem_reg;
        q_bits    = '0;
        trial     = '0;
        for (int i = 0; i < CHUNK_BITS; i++)
        begin
            trial = {chunk_rem, mag_reg[VALUE_WIDTH-1-i]};
            if (trial >= eff_radix)
            begin
                q_bits[CHUNK_BITS-1-i] = 1'b1;
                trial = trial - eff_radix;
            end
            chunk_rem = trial[DIGIT_WIDTH-1:0];
        end
    end

    // Address the digit for the next step and look up its symbol
    assign rd_index  = INDEX_WIDTH'(count_next - COUNT_WIDTH'(1));
    assign sym_table = {sym_high_reg, sym_low_reg};

    // Evaluate the jump condition
    always_comb
    begin
        unique case (cw.cond)
            COND_ALWAYS:     jump = 1'b1;
            COND_NOT_START:  jump = !start;
            COND_CHUNK_MORE: jump = (chunk_reg != CHUNK_CNT_W'(NUM_CHUNKS - 1));
            COND_MAG_MORE:   jump = (mag_reg != '0)
                                    && (count_reg != COUNT_WIDTH'(VALUE_WIDTH - 1));
            COND_COUNT_MORE: jump = (count_reg != COUNT_WIDTH'(1));
            COND_NEVER:      jump = 1'b0;
            default:         jump = 1'b0;
        endcase
    end

    // Execute the datapath operation of the current step
    always_comb
    begin
        pc_next     = jump ? cw.target : step_t'(pc_reg + step_t'(1));
        mag_next    = mag_reg;
        rem_next    = rem_reg;
        chunk_next  = chunk_reg;
        count_next  = count_reg;
        neg_next    = neg_reg;
        strobe_next = 1'b0;
        symbol_next = symbol_reg;
        last_next   = last_reg;
        buf_we      = 1'b0;
        unique case (cw.op)
            OP_NOP:
            begin
            end
            OP_LOAD:
            begin
                neg_next   = value[VALUE_WIDTH-1];
                mag_next   = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
                rem_next   = '0;
                chunk_next = '0;
                count_next = '0;
            end
            OP_DIV_CHUNK:
            begin
                mag_next   = {mag_reg[VALUE_WIDTH-CHUNK_BITS-1:0], q_bits};
                rem_next   = chunk_rem;
                chunk_next = CHUNK_CNT_W'(chunk_reg + CHUNK_CNT_W'(1));
            end
            OP_STORE:
            begin
                buf_we     = 1'b1;
                rem_next   = '0;
                chunk_next = '0;
                count_next = COUNT_WIDTH'(count_reg + COUNT_WIDTH'(1));
            end
            OP_SIGN:
            begin
                strobe_next = neg_reg;
                symbol_next = MINUS_CHAR;
                last_next   = 1'b0;
            end
            OP_EMIT:
            begin
                strobe_next = 1'b1;
                symbol_next = sym_table[{rd_digit_reg, 3'b000} +: SYMBOL_WIDTH];
                last_next   = (count_reg == COUNT_WIDTH'(1));
                count_next  = COUNT_WIDTH'(count_reg - COUNT_WIDTH'(1));
            end
            default:
            begin
            end
        endcase
    end

    // Hold configuration; update on a write transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg    <= RADIX_RESET;
            sym_low_reg  <= SYMBOLS_LOW_RESET;
            sym_high_reg <= SYMBOLS_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_RADIX)
                radix_reg <= cfg_data[RADIX_WIDTH-1:0];
            if (cfg_index == CFG_SYMBOLS_LOW)
                sym_low_reg <= cfg_data;
            if (cfg_index == CFG_SYMBOLS_HIGH)
                sym_high_reg <= cfg_data;
        end
    end

    // Advance the sequencer and the control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= STEP_IDLE;
            chunk_reg  <= '0;
            count_reg  <= '0;
            neg_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            pc_reg     <= pc_next;
            chunk_reg  <= chunk_next;
            count_reg  <= count_next;
            neg_reg    <= neg_next;
            strobe_reg <= strobe_next;
        end
    end

    // Update payload registers
    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        rem_reg    <= rem_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
    end

    // Store the finished digit, least significant first; fetch the digit for the next step
    always_ff @(posedge clk)
    begin
        if (buf_we)
            digit_buf[count_reg[INDEX_WIDTH-1:0]] <= rem_reg;
        rd_digit_reg <= digit_buf[rd_index];
    end

`ifndef SYNTHESIS
    // A character only leaves while a conversion is in progress
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("character strobed while idle");

    // The final character of a run is followed by a gap
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("character strobed right after last");

    // An accepted value starts the division
    a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (pc_reg == STEP_DIV && count_reg == '0))
        else $error("accepted value did not enter division");

    // Emission never reads past the stored digits
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_EMIT) |-> (count_reg != '0
            && count_reg <= COUNT_WIDTH'(VALUE_WIDTH)))
        else $error("digit count out of range during emission");

    // The digit count never exceeds the buffer depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_WIDTH'(VALUE_WIDTH))
        else $error("digit count overflow");
`endif

endmodule
